@@ sv/wcms_pkg.sv @@
// ----------------------------------------------------------------------------
// Windowed confidence mode switch package
// Shared item and result types, operation and register codes, reset values.
// ----------------------------------------------------------------------------
package wcms_pkg;

    localparam int unsigned FIELD_W = 7;
    localparam int unsigned THRESH_W = 9;
    localparam int unsigned FRAC_BITS = 8;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic CFG_WINDOW_SIZE = 1'b0;
    localparam logic CFG_THRESHOLD   = 1'b1;

    localparam logic [FIELD_W-1:0]  WINDOW_SIZE_RESET = 7'd16;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET   = 9'd230;

    typedef struct packed {
        logic [1:0] operation;
        logic       mispredicted;
    } wcms_item_t;

    typedef struct packed {
        logic               dual_path;
        logic [FIELD_W-1:0] held_count;
        logic [FIELD_W-1:0] correct_count;
    } wcms_result_t;

endpackage

@@ sv/windowed_confidence_mode_switch_unit.sv @@
// ----------------------------------------------------------------------------
// Windowed confidence mode switch
// Sliding window of branch outcome correctness with a Q1.8 accuracy threshold
// that selects dual-path execution mode.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while the result side does not
// stall and returns one result per item. An item is registered on entry,
// then the window, counts and mode are updated in one pass and the state
// after the item is captured in the output register; the core's state
// update, applied once per item, sets the rate.
module windowed_confidence_mode_switch_unit #(
    parameter int unsigned MAX_WINDOW = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    operation,
    input  logic                          mispredicted,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          dual_path,
    output logic [wcms_pkg::FIELD_W-1:0]  held_count,
    output logic [wcms_pkg::FIELD_W-1:0]  correct_count,
    input  logic                          cfg_write_en,
    input  logic                          cfg_index,
    input  logic [wcms_pkg::THRESH_W-1:0] cfg_data
);
    import wcms_pkg::*;

    logic                  in_valid_reg;
    wcms_item_t            item_reg;
    logic                  out_valid_reg;
    wcms_result_t          result_reg;
    wcms_result_t          core_result;
    logic [FIELD_W-1:0]    window_size_reg;
    logic [THRESH_W-1:0]   threshold_reg;
    logic                  advance;
    logic                  accept;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            window_size_reg <= WINDOW_SIZE_RESET;
            threshold_reg   <= THRESHOLD_RESET;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_SIZE: window_size_reg <= cfg_data[FIELD_W-1:0];
                    CFG_THRESHOLD:   threshold_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.operation    <= operation;
            item_reg.mispredicted <= mispredicted;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    wcms_core #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .item         (item_reg),
        .window_size  (window_size_reg),
        .threshold_q8 (threshold_reg),
        .result       (core_result)
    );

    assign out_valid     = out_valid_reg;
    assign dual_path     = result_reg.dual_path;
    assign held_count    = result_reg.held_count;
    assign correct_count = result_reg.correct_count;

endmodule

@@ sv/wcms_core.sv @@
// ----------------------------------------------------------------------------
// Windowed confidence mode switch core
// Holds the outcome window, running counts and mode, and applies one item
// per enabled cycle, presenting the state after that item as its result.
// ----------------------------------------------------------------------------
module wcms_core #(
    parameter int unsigned MAX_WINDOW = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  wcms_pkg::wcms_item_t          item,
    input  logic [wcms_pkg::FIELD_W-1:0]  window_size,
    input  logic [wcms_pkg::THRESH_W-1:0] threshold_q8,
    output wcms_pkg::wcms_result_t        result
);
    import wcms_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
    localparam int unsigned IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int unsigned WW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;
    localparam int unsigned PW = CW + THRESH_W;

    logic [MAX_WINDOW-1:0] hist_reg;
    logic [MAX_WINDOW-1:0] hist_next;
    logic [CW-1:0]         held_reg;
    logic [CW-1:0]         held_next;
    logic [CW-1:0]         corr_reg;
    logic [CW-1:0]         corr_next;
    logic                  dual_reg;
    logic                  dual_next;

    logic [WW-1:0]         win_ext;
    logic [CW-1:0]         held_d;
    logic [CW-1:0]         corr_d;
    logic [MAX_WINDOW-1:0] hist_d;
    logic                  do_push;
    logic                  correct;
    logic [PW-1:0]         lhs;
    logic [PW-1:0]         rhs;
    logic                  meets;

    assign correct = ~item.mispredicted;

    always_comb
    begin
        if (WW'(window_size) > WW'(MAX_WINDOW))
        begin
            win_ext = WW'(MAX_WINDOW);
        end
        else
        begin
            win_ext = WW'(window_size);
        end

        held_d  = held_reg;
        corr_d  = corr_reg;
        hist_d  = hist_reg;
        do_push = 1'b1;
        if (WW'(held_reg) + WW'(1) > win_ext)
        begin
            if (held_reg == '0)
            begin
                do_push = 1'b0;
            end
            else
            begin
                hist_d = hist_reg >> 1;
                held_d = held_reg - CW'(1);
                if (hist_reg[0])
                begin
                    corr_d = corr_reg - CW'(1);
                end
            end
        end

        hist_next = hist_reg;
        held_next = held_reg;
        corr_next = corr_reg;
        unique case (item.operation)
            OP_UPDATE:
            begin
                hist_next = hist_d;
                held_next = held_d;
                corr_next = corr_d;
                if (do_push)
                begin
                    hist_next[held_d[IW-1:0]] = correct;
                    held_next = held_d + CW'(1);
                    corr_next = corr_d + CW'(correct);
                end
            end
            OP_CLEAR:
            begin
                held_next = '0;
                corr_next = '0;
            end
            default:
            begin
            end
        endcase

        lhs   = PW'({corr_next, {FRAC_BITS{1'b0}}});
        rhs   = PW'(threshold_q8) * PW'(held_next);
        meets = (lhs >= rhs);

        unique case (item.operation)
            OP_UPDATE: dual_next = ~meets;
            OP_QUERY:  dual_next = (held_reg == '0) ? 1'b1 : ~meets;
            OP_CLEAR:  dual_next = 1'b1;
            default:   dual_next = dual_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            corr_reg <= '0;
            dual_reg <= 1'b1;
        end
        else if (step_en)
        begin
            held_reg <= held_next;
            corr_reg <= corr_next;
            dual_reg <= dual_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            hist_reg <= hist_next;
        end
    end

    assign result.dual_path     = dual_next;
    assign result.held_count    = FIELD_W'(held_next);
    assign result.correct_count = FIELD_W'(corr_next);

endmodule

@@ sv/wcms_checker.sv @@
// ----------------------------------------------------------------------------
// Windowed confidence mode switch checker
// Port-level properties of the input stall and the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module wcms_checker #(
    parameter int unsigned MAX_WINDOW = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          dual_path,
    input logic [wcms_pkg::FIELD_W-1:0]  held_count,
    input logic [wcms_pkg::FIELD_W-1:0]  correct_count
);
    import wcms_pkg::*;

    localparam bit SMALL_WINDOW = (MAX_WINDOW < 128);

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && SMALL_WINDOW |-> held_count <= FIELD_W'(MAX_WINDOW))
        else $error("held count exceeds the window capacity");

    a_correct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && SMALL_WINDOW |-> correct_count <= held_count)
        else $error("correct count exceeds held count");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the result side is free");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dual_path)
        && $stable(held_count) && $stable(correct_count))
        else $error("stalled result item changed");

endmodule

bind windowed_confidence_mode_switch_unit wcms_checker #(
    .MAX_WINDOW(MAX_WINDOW)
) u_wcms_checker (.*);

@@ dv/windowed_confidence_mode_switch_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Windowed confidence mode switch testbench
// Drives update, query, clear and reserved items through the unit under changing
// window and threshold settings, with random input gaps and output stalls.
// Each result is checked against a cycle-free copy of the window, its counts
// and the dual-path decision.
// ----------------------------------------------------------------------------
module windowed_confidence_mode_switch_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wcms_pkg::*;

    localparam int unsigned WINDOW_DEPTH   = 64;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned QUIET_LIMIT    = 3000;
    localparam int unsigned REPORT_SLOTS   = 16;
    localparam logic [1:0]  OP_RESERVED    = 2'd3;

    typedef enum int unsigned {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_style_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          operation;
    logic                mispredicted;
    logic                out_valid;
    logic                out_stall;
    logic                dual_path;
    logic [FIELD_W-1:0]  held_count;
    logic [FIELD_W-1:0]  correct_count;
    logic                cfg_write_en;
    logic                cfg_index;
    logic [THRESH_W-1:0] cfg_data;

    logic [WINDOW_DEPTH-1:0] outcome_ring = '0;
    int unsigned             ring_head    = 0;
    int unsigned             win_held     = 0;
    int unsigned             win_correct  = 0;
    logic                    dual_mode    = 1'b1;
    int unsigned             win_size     = WINDOW_SIZE_RESET;
    int unsigned             thresh_q8    = THRESHOLD_RESET;

    wcms_result_t reports_due [REPORT_SLOTS];
    int unsigned  due_head = 0;
    int unsigned  due_tail = 0;
    wcms_result_t due_report;
    int unsigned  failures = 0;
    int unsigned  quiet_cycles = 0;

    bit           sender_gaps = 1'b1;
    int unsigned  burst_left = 0;
    bit           holdoff_request = 1'b0;
    bit           holdoff_active = 1'b0;
    stall_style_t stall_style = STALL_NONE;
    int unsigned  style_left = 0;
    int unsigned  stall_phase = 0;

    windowed_confidence_mode_switch_unit #(
        .MAX_WINDOW(WINDOW_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .mispredicted(mispredicted),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .dual_path(dual_path),
        .held_count(held_count),
        .correct_count(correct_count),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic below_threshold();
        return (win_correct * 256) < (thresh_q8 * win_held);
    endfunction

    function automatic wcms_result_t predict_mode_step(logic [1:0] op, logic mis);
        int unsigned  limit;
        wcms_result_t step_result;
        limit = (win_size > WINDOW_DEPTH) ? WINDOW_DEPTH : win_size;
        case (op)
            OP_UPDATE:
            begin
                if (win_held + 1 <= limit || win_held != 0)
                begin
                    if (win_held + 1 > limit)
                    begin
                        if (outcome_ring[ring_head])
                            win_correct--;
                        outcome_ring[ring_head] = 1'b0;
                        ring_head = (ring_head + 1) % WINDOW_DEPTH;
                        win_held--;
                    end
                    outcome_ring[(ring_head + win_held) % WINDOW_DEPTH] = !mis;
                    win_held++;
                    if (!mis)
                        win_correct++;
                end
                dual_mode = below_threshold();
            end
            OP_QUERY:
            begin
                dual_mode = (win_held == 0) ? 1'b1 : below_threshold();
            end
            OP_CLEAR:
            begin
                outcome_ring = '0;
                ring_head = 0;
                win_held = 0;
                win_correct = 0;
                dual_mode = 1'b1;
            end
            default:
            begin
            end
        endcase
        step_result.dual_path = dual_mode;
        step_result.held_count = FIELD_W'(win_held);
        step_result.correct_count = FIELD_W'(win_correct);
        return step_result;
    endfunction

    function automatic logic [1:0] pick_operation(int unsigned clear_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < clear_pct)
            return OP_CLEAR;
        else if (r < clear_pct + 4)
            return OP_RESERVED;
        else if (r < clear_pct + 16)
            return OP_QUERY;
        return OP_UPDATE;
    endfunction

    task automatic send_item(logic [1:0] op, logic mis);
        int unsigned gap;
        if (sender_gaps && burst_left == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        else if (burst_left > 0)
        begin
            burst_left--;
        end
        in_valid <= 1'b1;
        operation <= op;
        mispredicted <= mis;
        do
            @(posedge clk);
        while (in_stall);
        reports_due[due_tail % REPORT_SLOTS] = predict_mode_step(op, mis);
        due_tail++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (due_head != due_tail)
            @(posedge clk);
    endtask

    task automatic set_config(int unsigned window, int unsigned threshold);
        drain_results();
        cfg_write_en <= 1'b1;
        cfg_index <= CFG_WINDOW_SIZE;
        cfg_data <= THRESH_W'(window & 'h7F);
        @(posedge clk);
        cfg_index <= CFG_THRESHOLD;
        cfg_data <= THRESH_W'(threshold & 'h1FF);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        win_size = window & 'h7F;
        thresh_q8 = threshold & 'h1FF;
    endtask

    task automatic test_reset_defaults();
        send_item(OP_QUERY, 1'b0);
        send_item(OP_RESERVED, 1'b1);
        send_item(OP_UPDATE, 1'b0);
        send_item(OP_UPDATE, 1'b1);
        send_item(OP_CLEAR, 1'b0);
        send_item(OP_QUERY, 1'b1);
    endtask

    task automatic test_window_extremes();
        set_config(1, 256);
        send_item(OP_UPDATE, 1'b0);
        send_item(OP_UPDATE, 1'b1);
        send_item(OP_UPDATE, 1'b0);
        set_config(0, 0);
        send_item(OP_UPDATE, 1'b1);
        send_item(OP_CLEAR, 1'b0);
        send_item(OP_UPDATE, 1'b0);
        send_item(OP_QUERY, 1'b0);
        set_config(127, 511);
        send_item(OP_UPDATE, 1'b0);
        send_item(OP_UPDATE, 1'b0);
    endtask

    task automatic test_window_shrink();
        set_config(64, 128);
        send_item(OP_CLEAR, 1'b0);
        for (int i = 0; i < 8; i++)
            send_item(OP_UPDATE, logic'(i % 3 == 0));
        set_config(3, 128);
        send_item(OP_UPDATE, 1'b0);
        send_item(OP_UPDATE, 1'b1);
        send_item(OP_QUERY, 1'b0);
    endtask

    task automatic test_random_phases();
        int unsigned window;
        int unsigned threshold;
        int unsigned mis_pct;
        int unsigned clear_pct;
        int unsigned r;
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0:
                begin
                    window = 1;
                    threshold = 0;
                end
                1:
                begin
                    window = 64;
                    threshold = 256;
                end
                2:
                begin
                    window = 0;
                    threshold = $urandom_range(0, 2);
                end
                3:
                begin
                    window = 127;
                    threshold = 511;
                end
                default:
                begin
                    r = $urandom_range(0, 9);
                    window = (r == 0) ? 0 : (r == 1) ? $urandom_range(65, 127)
                                                     : $urandom_range(1, 64);
                    r = $urandom_range(0, 9);
                    threshold = (r == 0) ? $urandom_range(257, 511)
                              : (r == 1) ? 256 * $urandom_range(0, 1)
                                         : $urandom_range(0, 256);
                end
            endcase
            r = $urandom_range(0, 9);
            mis_pct = (r == 0) ? 0 : (r == 1) ? 100 : $urandom_range(2, 50);
            clear_pct = (ph == 2) ? 8 : 2 * $urandom_range(0, 2);
            sender_gaps = ($urandom_range(0, 3) != 0);
            set_config(window, threshold);
            repeat (75)
                send_item(pick_operation(clear_pct), logic'($urandom_range(0, 99) < mis_pct));
        end
    endtask

    task automatic test_output_holdoff();
        drain_results();
        sender_gaps = 1'b0;
        holdoff_request = 1'b1;
        while (!holdoff_active)
            @(posedge clk);
        repeat (48)
            send_item(pick_operation(2), logic'($urandom_range(0, 1)));
        drain_results();
        sender_gaps = 1'b1;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        operation <= OP_UPDATE;
        mispredicted <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index <= CFG_WINDOW_SIZE;
        cfg_data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_window_extremes();
        test_window_shrink();
        test_output_holdoff();
        test_random_phases();
        drain_results();
        repeat (8) @(posedge clk);
        if (failures == 0 && due_head == due_tail)
            $display("windowed_confidence_mode_switch_unit_tb: done, clean");
        else
            $display("windowed_confidence_mode_switch_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (holdoff_request)
            begin
                holdoff_active = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                holdoff_request = 1'b0;
                holdoff_active = 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    stall_style = stall_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(40, 250);
                    stall_phase = 0;
                end
                style_left--;
                stall_phase++;
                case (stall_style)
                    STALL_NONE:     out_stall <= 1'b0;
                    STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: out_stall <= ((stall_phase % 7) < 3);
                    default:        out_stall <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_head == due_tail)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with no item pending: %s=%0b held=%0d correct=%0d",
                             $time, "dual_path", dual_path, held_count, correct_count);
            end
            else
            begin
                due_report = reports_due[due_head % REPORT_SLOTS];
                due_head++;
                if (due_report.dual_path !== dual_path
                    || due_report.held_count !== held_count
                    || due_report.correct_count !== correct_count)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: expected dual_path=%0b held=%0d correct=%0d, %s",
                                 $time, due_report.dual_path, due_report.held_count,
                                 due_report.correct_count, "got");
                    if (failures <= 10)
                        $display("    actual dual_path=%0b held=%0d correct=%0d",
                                 dual_path, held_count, correct_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("windowed_confidence_mode_switch_unit_tb: done, errors");
            $finish;
        end
    end

endmodule
